// File: src/assert_macros.svh
// Assertion macros used by the checker file ksi_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`endif

// File: src/ksi_pkg.sv
// ----------------------------------------------------------------------------
// ksi_pkg
// Types, constants and helpers shared by the segment interpolator stages.
// ----------------------------------------------------------------------------
package ksi_pkg;
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;
  localparam logic [1:0] MODE_BEZIER = 2'd2;
  localparam logic [1:0] MODE_EASE   = 2'd3;

  localparam int DIV_STEPS = 16;     // quotient bits of the fraction
  localparam int DIV_PER_STAGE = 2;  // restoring steps per divider stage
  localparam int DIV_STAGES = 8;     // ceil(16 / 2)

  // Wide signed words for control points and lerp intermediates.
  typedef logic signed [23:0] wval_t;

  // Request context that travels alongside the divider.
  typedef struct packed {
    logic [1:0]   mode;
    logic         hold;      // result is start value
    logic [1:0]   tclamp;    // 0 divide, 1 zero, 2 one
    logic signed [15:0] v0;
    logic signed [15:0] v1;
    logic signed [15:0] tout;
    logic signed [15:0] tin;
  } ctx_t;

  localparam logic [1:0] TC_DIV  = 2'd0;
  localparam logic [1:0] TC_ZERO = 2'd1;
  localparam logic [1:0] TC_ONE  = 2'd2;

  // a + rnd((b-a)*t, 16), t in 0..65536.
  function automatic wval_t lerp16(input wval_t a, input wval_t b, input logic [16:0] t);
    logic signed [42:0] p;
    begin
      p = (43'(b) - 43'(a)) * $signed({1'b0, t});
      p = p + 43'sd32768;
      lerp16 = a + wval_t'(p >>> 16);
    end
  endfunction
endpackage

// File: src/ksi_divider.sv
// ----------------------------------------------------------------------------
// ksi_divider
// Pipelined restoring divider: floor(num * 65536 / den) with num < den.
// Two quotient bits per stage, context carried alongside.
// ----------------------------------------------------------------------------
module ksi_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  logic [31:0]    num,
  input  logic [31:0]    den,
  input  ksi_pkg::ctx_t  in_ctx,
  output logic           out_valid,
  output logic [16:0]    quot,
  output ksi_pkg::ctx_t  out_ctx
);
  import ksi_pkg::*;

  logic [DIV_STAGES:0]        vld;
  logic [32:0]                rem [DIV_STAGES+1];
  logic [31:0]                dv  [DIV_STAGES+1];
  logic [16:0]                q   [DIV_STAGES+1];
  ctx_t                       cx  [DIV_STAGES+1];

  assign vld[0] = in_valid;
  assign rem[0] = {1'b0, num};
  assign dv[0]  = den;
  assign q[0]   = '0;
  assign cx[0]  = in_ctx;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [32:0] r_c;
    logic [16:0] q_c;
    always_comb begin
      logic [33:0] sh;
      r_c = rem[s];
      q_c = q[s];
      for (int k = 0; k < DIV_PER_STAGE; k++) begin
        if (s * DIV_PER_STAGE + k < DIV_STEPS) begin
          sh = {r_c, 1'b0};
          if (sh >= {2'b0, dv[s]}) begin
            r_c = 33'(sh - {2'b0, dv[s]});
            q_c = {q_c[15:0], 1'b1};
          end else begin
            r_c = sh[32:0];
            q_c = {q_c[15:0], 1'b0};
          end
        end
      end
    end
    // Sixteen shift-and-subtract steps give the fraction bits; num < den keeps the
    // integer part at zero.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
      if (adv) begin
        rem[s+1] <= r_c;
        q[s+1]   <= q_c;
        dv[s+1]  <= dv[s];
        cx[s+1]  <= cx[s];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign quot      = q[DIV_STAGES];
  assign out_ctx   = cx[DIV_STAGES];
endmodule

// File: src/ksi_curve.sv
// ----------------------------------------------------------------------------
// ksi_curve
// Pipelined curve evaluation from the fraction: ease, bezier, lerp, saturate.
// ----------------------------------------------------------------------------
module ksi_curve (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [16:0]         tq,
  input  ksi_pkg::ctx_t       in_ctx,
  output logic                out_valid,
  output logic signed [15:0]  result
);
  import ksi_pkg::*;

  // Stage A: final fraction, square and tangent products.
  logic        va;
  logic [16:0] ta;
  ctx_t        ca;
  logic [33:0] sq_a;
  logic signed [33:0] pt_o, pt_i;
  logic [16:0] tsel;
  logic [16:0] span_c;

  always_comb begin
    unique case (in_ctx.tclamp)
      TC_ZERO: tsel = 17'd0;
      TC_ONE:  tsel = 17'd65536;
      default: tsel = tq;
    endcase
    span_c = (in_ctx.v1 >= in_ctx.v0) ? 17'(18'(in_ctx.v1) - 18'(in_ctx.v0))
                                      : 17'(18'(in_ctx.v0) - 18'(in_ctx.v1));
  end

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (adv) va <= in_valid;
    if (adv) begin
      ta   <= tsel;
      ca   <= in_ctx;
      sq_a <= 34'(tsel) * 34'(tsel);
      pt_o <= 34'(in_ctx.tout) * $signed({1'b0, span_c});
      pt_i <= 34'(in_ctx.tin) * $signed({1'b0, span_c});
    end
  end

  // Stage B: rounded square and control points (divide by 12288 = 3*4096).
  logic        vb;
  logic [16:0] tb;
  ctx_t        cb;
  logic [17:0] sq_b;
  wval_t       p1_b, p2_b;

  function automatic wval_t div12288(input logic signed [33:0] x);
    logic signed [34:0] y;
    logic signed [22:0] hi;
    logic signed [22:0] qd;
    logic signed [23:0] rm;
    begin
      y  = 35'(x) + 35'sd6144;
      hi = 23'(y >>> 12);              // floor(y / 4096)
      // floor(hi / 3) by reciprocal with correction.
      qd = 23'((44'(hi) * 44'sd699051) >>> 21);
      rm = 24'(hi) - 24'(qd) * 24'sd3;
      if (rm >= 24'sd3) qd = qd + 23'sd1;
      else if (rm < 24'sd0) qd = qd - 23'sd1;
      div12288 = wval_t'(qd);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (adv) vb <= va;
    if (adv) begin
      tb   <= ta;
      cb   <= ca;
      sq_b <= 18'((sq_a + 34'd32768) >> 16);
      p1_b <= wval_t'(ca.v0) + div12288(pt_o);
      p2_b <= wval_t'(ca.v1) - div12288(pt_i);
    end
  end

  // Stage C: ease product and first de Casteljau level.
  logic        vc;
  logic [16:0] tc;
  ctx_t        cc;
  logic [35:0] ep_c;
  wval_t       a_c, b_c, c_c;

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (adv) vc <= vb;
    if (adv) begin
      tc   <= tb;
      cc   <= cb;
      ep_c <= 36'(sq_b) * 36'(19'd196608 - {tb, 1'b0});
      a_c  <= lerp16(wval_t'(cb.v0), p1_b, tb);
      b_c  <= lerp16(p1_b, p2_b, tb);
      c_c  <= lerp16(p2_b, wval_t'(cb.v1), tb);
    end
  end

  // Stage D: eased fraction and second level.
  logic        vd;
  logic [16:0] td, ed;
  ctx_t        cd;
  wval_t       d_d, e_d;
  logic [19:0] e_raw;

  assign e_raw = 20'((ep_c + 36'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (adv) vd <= vc;
    if (adv) begin
      td  <= tc;
      cd  <= cc;
      ed  <= (e_raw > 20'd65536) ? 17'd65536 : e_raw[16:0];
      d_d <= lerp16(a_c, b_c, tc);
      e_d <= lerp16(b_c, c_c, tc);
    end
  end

  // Stage E: start value on hold, else final lerp by mode, then saturation.
  wval_t r_e;
  always_comb begin
    if (cd.hold) begin
      r_e = wval_t'(cd.v0);
    end else begin
      case (cd.mode)
        MODE_BEZIER: r_e = lerp16(d_d, e_d, td);
        MODE_EASE:   r_e = lerp16(wval_t'(cd.v0), wval_t'(cd.v1), ed);
        default:     r_e = lerp16(wval_t'(cd.v0), wval_t'(cd.v1), td);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vd;
    if (adv) begin
      if (r_e > 24'sd32767)       result <= 16'sh7fff;
      else if (r_e < -24'sd32768) result <= -16'sh8000;
      else                        result <= r_e[15:0];
    end
  end
endmodule

// File: src/keyframe_segment_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_segment_interpolator
// Evaluates one keyframe segment (step, linear, ease or bezier) per request.
// ----------------------------------------------------------------------------
//  channel   direction  handshake         payload
//  input     in         valid / stall     times, values, tangents, mode
//  output    out        out_valid / out_stall  result_value
//
// One request enters per cycle while stall is low: an 8-stage divider
// forms the fraction, then five curve stages follow, thirteen register
// stages in all. The whole pipeline advances together; out_stall holds
// every stage, and stall follows it only while the last stage holds a
// result, so no request is lost or repeated. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module keyframe_segment_interpolator (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               stall,
  input  logic [31:0]        query_time,
  input  logic [31:0]        start_key_time,
  input  logic [31:0]        end_key_time,
  input  logic signed [15:0] start_key_value,
  input  logic signed [15:0] end_key_value,
  input  logic signed [15:0] tangent_out,
  input  logic signed [15:0] tangent_in,
  input  logic [1:0]         mode,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] result_value
);
  import ksi_pkg::*;

  logic  adv;
  ctx_t  ctx_in, ctx_div;
  logic  div_valid;
  logic [16:0] div_q;

  // The pipeline moves unless a finished result is waiting downstream.
  assign adv   = !(out_valid && out_stall);
  assign stall = !adv;

  // Classify the request: holding cases and clamped fractions skip the quotient.
  always_comb begin
    ctx_in.mode = mode;
    ctx_in.hold = (start_key_time >= end_key_time) || (mode == MODE_STEP);
    ctx_in.v0   = start_key_value;
    ctx_in.v1   = end_key_value;
    ctx_in.tout = tangent_out;
    ctx_in.tin  = tangent_in;
    if (query_time <= start_key_time)    ctx_in.tclamp = TC_ZERO;
    else if (query_time >= end_key_time) ctx_in.tclamp = TC_ONE;
    else                                 ctx_in.tclamp = TC_DIV;
  end

  ksi_divider u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(valid),
    .num(query_time - start_key_time),
    .den(end_key_time - start_key_time),
    .in_ctx(ctx_in),
    .out_valid(div_valid), .quot(div_q), .out_ctx(ctx_div)
  );

  ksi_curve u_curve (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(div_valid), .tq(div_q), .in_ctx(ctx_div),
    .out_valid(out_valid), .result(result_value)
  );
endmodule

// File: src/ksi_checker.sv
// ----------------------------------------------------------------------------
// ksi_checker
// Port-level checks on the segment interpolator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ksi_checker (
  input logic               clk,
  input logic               rst,
  input logic               valid,
  input logic               stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] result_value
);
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(result_value), "result changed while stalled")
  `ASSERT_IMPL(a_stall_src, clk, rst, stall, out_valid && out_stall, "input stalled without output stall")
  `ASSERT_IMPL(a_free, clk, rst, !out_valid, !stall, "input stalled with empty output")
  `ASSERT_NEXT(a_reset, clk, 1'b0, rst, !out_valid, "output valid after reset")
endmodule

bind keyframe_segment_interpolator ksi_checker u_chk (
  .clk(clk), .rst(rst), .valid(valid), .stall(stall),
  .out_valid(out_valid), .out_stall(out_stall), .result_value(result_value)
);

// File: dv/keyframe_segment_interpolator_tb.sv
// ----------------------------------------------------------------------------
// keyframe_segment_interpolator_tb
// Drives keyframe segments into the interpolator and checks every result
// against a fixed-point curve predictor kept inside the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keyframe_segment_interpolator_tb;
  import ksi_pkg::*;

  logic               clk;
  logic               rst;
  logic               valid;
  logic               stall;
  logic [31:0]        query_time;
  logic [31:0]        start_key_time;
  logic [31:0]        end_key_time;
  logic signed [15:0] start_key_value;
  logic signed [15:0] end_key_value;
  logic signed [15:0] tangent_out;
  logic signed [15:0] tangent_in;
  logic [1:0]         mode;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] result_value;

  // Expected curve values, oldest first.
  logic signed [15:0] curve_values_due[$];
  int                 error_count;
  // While set, neither side idles.
  bit                 steady_phase;

  keyframe_segment_interpolator i_dut (
    .clk             (clk),
    .rst             (rst),
    .valid           (valid),
    .stall           (stall),
    .query_time      (query_time),
    .start_key_time  (start_key_time),
    .end_key_time    (end_key_time),
    .start_key_value (start_key_value),
    .end_key_value   (end_key_value),
    .tangent_out     (tangent_out),
    .tangent_in      (tangent_in),
    .mode            (mode),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_value    (result_value)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Rounds half toward plus infinity after dropping s fraction bits. An
  // arithmetic shift is a floor, so adding the half first does the job.
  function automatic longint round_shift(input longint x, input int s);
    longint y;
    y = x + (longint'(1) <<< (s - 1));
    return y >>> s;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint t);
    return a + round_shift((b - a) * t, 16);
  endfunction

  // Floor division; the divisor is always positive here.
  function automatic longint floor_quot(input longint x, input longint d);
    longint q;
    q = x / d;
    if ((x % d) != 0 && x < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  // Computes the saturated curve value of one segment at the query time.
  function automatic logic signed [15:0] curve_value(
    input logic [31:0] now, input logic [31:0] t0, input logic [31:0] t1,
    input logic signed [15:0] v0s, input logic signed [15:0] v1s,
    input logic signed [15:0] tos, input logic signed [15:0] tis,
    input logic [1:0] md);
    longint v0, v1, r, t, sq, e, span, p1, p2, a, b, c, d, f;
    v0 = v0s;
    v1 = v1s;
    if (t0 >= t1 || md == MODE_STEP) begin
      r = v0;
    end else begin
      // Fraction of the segment in Q1.16, with 1.0 held as 65536.
      if (now <= t0) begin
        t = 0;
      end else if (now >= t1) begin
        t = 65536;
      end else begin
        t = ((longint'(now - t0)) <<< 16) / longint'(t1 - t0);
      end
      if (md == MODE_EASE) begin
        sq = round_shift(t * t, 16);
        e = round_shift(sq * (3 * 65536 - 2 * t), 16);
        if (e > 65536) begin
          e = 65536;
        end
        r = blend(v0, v1, e);
      end else if (md == MODE_BEZIER) begin
        span = (v1 > v0) ? v1 - v0 : v0 - v1;
        p1 = v0 + floor_quot(longint'(tos) * span + 6144, 12288);
        p2 = v1 - floor_quot(longint'(tis) * span + 6144, 12288);
        a = blend(v0, p1, t);
        b = blend(p1, p2, t);
        c = blend(p2, v1, t);
        d = blend(a, b, t);
        f = blend(b, c, t);
        r = blend(d, f, t);
      end else begin
        r = blend(v0, v1, t);
      end
    end
    if (r > 32767) begin
      r = 32767;
    end
    if (r < -32768) begin
      r = -32768;
    end
    return 16'(r);
  endfunction

  // Sends one request, waits for it to be taken, and books its result.
  task automatic send_segment(
    input logic [31:0] now, input logic [31:0] t0, input logic [31:0] t1,
    input logic signed [15:0] v0, input logic signed [15:0] v1,
    input logic signed [15:0] tout, input logic signed [15:0] tin,
    input logic [1:0] md);
    while (!steady_phase && $urandom_range(99) < 9) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid           <= 1'b1;
    query_time      <= now;
    start_key_time  <= t0;
    end_key_time    <= t1;
    start_key_value <= v0;
    end_key_value   <= v1;
    tangent_out     <= tout;
    tangent_in      <= tin;
    mode            <= md;
    @(posedge clk);
    while (stall) begin
      @(posedge clk);
    end
    curve_values_due = {curve_values_due, curve_value(now, t0, t1, v0, v1, tout, tin, md)};
  endtask

  // Drops valid once the current request is gone.
  task automatic go_quiet();
    valid <= 1'b0;
    @(posedge clk);
  endtask

  // Every result is checked against the oldest booked value.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (curve_values_due.size() == 0) begin
        $display("%0t: unexpected result %0d", $time, result_value);
        error_count++;
      end else begin
        if (result_value !== curve_values_due[0]) begin
          $display("%0t: result_value expected %0d actual %0d", $time,
                   curve_values_due[0], result_value);
          error_count++;
        end
        void'(curve_values_due.pop_front());
      end
    end
  end

  // The receiver stalls at random except during the steady phase.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady_phase && ($urandom_range(99) < 9);
    end
  end

  // Random 16-bit value that favors the range ends and zero.
  function automatic logic [15:0] edgy16();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Extremes of every field, each mode, and the named special cases.
  task automatic test_directed();
    logic [1:0] md;
    for (int k = 0; k < 4; k++) begin
      md = 2'(k);
      // Query inside, before and after a segment.
      send_segment(32'd150, 32'd100, 32'd200, 16'sh8000, 16'sh7fff, 16'sh7fff,
                   16'sh8000, md);
      send_segment(32'd0, 32'd100, 32'd200, 16'sh1000, -16'sh1000, 16'sd0,
                   16'sd0, md);
      send_segment(32'hffffffff, 32'd100, 32'd200, 16'sh1000, -16'sh1000,
                   16'sd4096, 16'sd4096, md);
      // Keys not in order, and keys equal.
      send_segment(32'd5, 32'hffffffff, 32'd0, 16'sh7fff, 16'sh8000, 16'sh7fff,
                   16'sh7fff, md);
      send_segment(32'd7, 32'd7, 32'd7, -16'sd3, 16'sh7fff, 16'sd0, 16'sd0, md);
    end
    // Bezier overshoot in both directions, full time range.
    send_segment(32'h80000000, 32'd0, 32'hffffffff, 16'sh8000, 16'sh7fff,
                 16'sh7fff, 16'sh7fff, MODE_BEZIER);
    send_segment(32'h40000000, 32'd0, 32'hffffffff, 16'sh7fff, 16'sh8000,
                 16'sh7fff, 16'sh7fff, MODE_BEZIER);
    send_segment(32'hfffffffe, 32'd0, 32'hffffffff, 16'sh8000, 16'sh7fff,
                 16'sh8000, 16'sh8000, MODE_BEZIER);
    go_quiet();
  endtask

  // Random segments; most are ordered with the query near the segment.
  task automatic test_random(input int count);
    logic [31:0] t0, t1, now;
    for (int n = 0; n < count; n++) begin
      steady_phase = (n >= count / 2) && (n < count / 2 + 300);
      t0 = $urandom;
      t1 = $urandom;
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(1)) begin
          t0 = $urandom_range(32'h00ffffff);
          t1 = t0 + 32'($urandom_range(1, 5000));
        end else if (t0 > t1) begin
          {t0, t1} = {t1, t0};
        end
        if (t0 == t1) begin
          t1 = t0 + 1;
        end
        case ($urandom_range(9))
          0: now = t0 - 32'($urandom_range(3));
          1: now = t1 + 32'($urandom_range(3));
          default: now = t0 + 32'(longint'($urandom) % (longint'(t1 - t0) + 1));
        endcase
      end else begin
        now = $urandom;
      end
      send_segment(now, t0, t1, edgy16(), edgy16(), edgy16(), edgy16(),
                   2'($urandom_range(3)));
    end
    steady_phase = 1'b0;
    go_quiet();
  endtask

  // Sender holds off until the pipeline has drained completely.
  task automatic test_drain_pause();
    wait (curve_values_due.size() == 0);
    @(posedge clk);
    for (int n = 0; n < 10; n++) begin
      send_segment($urandom, 32'd0, 32'd1000, edgy16(), edgy16(), edgy16(),
                   edgy16(), 2'($urandom_range(3)));
    end
    go_quiet();
  endtask

  initial begin
    rst = 1'b1;
    valid = 1'b0;
    query_time = '0;
    start_key_time = '0;
    end_key_time = '0;
    start_key_value = '0;
    end_key_value = '0;
    tangent_out = '0;
    tangent_in = '0;
    mode = MODE_LINEAR;
    error_count = 0;
    steady_phase = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_drain_pause();
    test_random(900);
    wait (curve_values_due.size() == 0);
    repeat (40) @(posedge clk);
    if (error_count == 0 && curve_values_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
